### hw/rtl/cpe_pkg.sv
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types and constants of the coast-down power estimator.
// ----------------------------------------------------------------------------
package cpe_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int WIDE_W = 152;
  localparam int MUL_W  = 34;
  localparam int Q_W    = 17;
  localparam int NUM_W  = 76;
  localparam int STEP_W = 6;

  localparam logic [1:0] REG_WHEEL = 2'd0;
  localparam logic [1:0] REG_MASS  = 2'd1;
  localparam logic [1:0] REG_VMIN  = 2'd2;

  localparam logic OP_PULSE  = 1'b0;
  localparam logic OP_BUTTON = 1'b1;

  typedef enum logic [2:0] {
    U_NOP,
    U_LOAD,
    U_LOADB,
    U_MOVE,
    U_MUL,
    U_DIV
  } unit_op_t;

  typedef struct packed {
    unit_op_t            op;
    logic [WIDE_W-1:0]   a_val;
    logic [WIDE_W-1:0]   b_val;
    logic [MUL_W-1:0]    m_val;
  } unit_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SPEED,
    S_SPEED_RUN,
    S_NUM_LD,
    S_NUM_RUN,
    S_NUM_MV,
    S_DEN_LD,
    S_DEN_RUN,
    S_DEN_MV,
    S_CDIV_LD,
    S_CDIV_RUN,
    S_POST,
    S_SRCH_ST,
    S_SEARCH,
    S_FRIC,
    S_INT_LD1,
    S_INT_RUN1,
    S_INT_LD2,
    S_INT_RUN2,
    S_IDIV_LD,
    S_IDIV_RUN,
    S_IFIN,
    S_EST,
    S_DONE
  } state_t;

endpackage

### hw/rtl/cpe_ram.sv
// ----------------------------------------------------------------------------
// cpe_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### hw/rtl/cpe_unit.sv
// ----------------------------------------------------------------------------
// cpe_unit
// Shared shift-add multiplier and restoring divider around one wide adder.
// ----------------------------------------------------------------------------
module cpe_unit import cpe_pkg::*; (
  input  logic              clk,
  input  unit_cmd_t         cmd,
  output logic [WIDE_W-1:0] a_o,
  output logic [Q_W-1:0]    q_o
);

  logic [WIDE_W-1:0] a_r, a_nxt;
  logic [WIDE_W-1:0] b_r, b_nxt;
  logic [MUL_W-1:0]  m_r, m_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [WIDE_W-1:0] opnd;
  logic              sub;
  logic [WIDE_W:0]   res;

  assign sub  = (cmd.op == U_DIV);
  assign opnd = sub ? ~b_r : b_r;
  assign res  = {1'b0, a_r} + {1'b0, opnd} + {{WIDE_W{1'b0}}, sub};

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    m_nxt = m_r;
    q_nxt = q_r;
    unique case (cmd.op)
      U_LOAD: begin
        a_nxt = cmd.a_val;
        b_nxt = cmd.b_val;
        m_nxt = cmd.m_val;
        q_nxt = '0;
      end
      U_LOADB: begin
        b_nxt = cmd.b_val;
        m_nxt = cmd.m_val;
      end
      U_MOVE: begin
        b_nxt = a_r;
        a_nxt = '0;
        m_nxt = cmd.m_val;
      end
      U_MUL: begin
        if (m_r[0]) begin
          a_nxt = res[WIDE_W-1:0];
        end
        b_nxt = b_r << 1;
        m_nxt = m_r >> 1;
      end
      U_DIV: begin
        if (res[WIDE_W]) begin
          a_nxt = res[WIDE_W-1:0];
        end
        q_nxt = {q_r[Q_W-2:0], res[WIDE_W]};
        b_nxt = b_r >> 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    m_r <= m_nxt;
    q_r <= q_nxt;
  end

  assign a_o = a_r;
  assign q_o = q_r;

endmodule

### hw/rtl/coastdown_power_estimator.sv
// ----------------------------------------------------------------------------
// coastdown_power_estimator
// Speed and coast-down power from wheel pulse timestamps, with a recorded
// friction curve that is interpolated to estimate rider power.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_ready   operation, pulse_time_ms
//  out_     output     out_valid / out_ready speed .. table_entries
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A button item, or a pulse with an invalid window, goes straight to the output
// register. A pulse with a valid window runs the shift-add and restoring-divide
// passes of the shared wide adder; outside record mode it also walks the curve
// table through the curve memory read port and, when it interpolates, runs
// further multiply and divide passes.
// No clearing pass follows reset: the fill count marks the live entries.
// A finished item waits in the output register while the next is accepted.
// ----------------------------------------------------------------------------
module coastdown_power_estimator import cpe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_operation,
  input  logic [31:0]              in_pulse_time_ms,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_speed_code,
  output logic signed [15:0]       out_coast_power_w,
  output logic signed [15:0]       out_estimated_power_w,
  output logic                     out_window_valid,
  output logic                     out_recording,
  output logic                     out_point_stored,
  output logic [CNT_W-1:0]         out_table_entries,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [11:0]              cfg_data
);

  state_t state_r, state_nxt;

  logic [11:0] wheel_r;
  logic [7:0]  mass_r;
  logic [3:0]  vmin_r;

  logic [31:0]      pt_r [4];
  logic [31:0]      pt_nxt [4];
  logic [3:0]       iv_r, iv_nxt;
  logic             rec_r, rec_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       last_r, last_nxt;

  logic [MUL_W-1:0]  t20_r, t20_nxt, t31_r, t31_nxt, t42_r, t42_nxt;
  logic [31:0]       diff_r, diff_nxt;
  logic              neg_r, neg_nxt;
  logic [7:0]        speed_r, speed_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [15:0]       coast_r, coast_nxt;
  logic [15:0]       est_r, est_nxt;
  logic              valid_r, valid_nxt;
  logic              stored_r, stored_nxt;
  logic [1:0]        fac_r, fac_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [7:0]        prev_s_r, prev_s_nxt, prev_p_r, prev_p_nxt;
  logic [7:0]        sb_r, sb_nxt, pb_r, pb_nxt;
  logic [9:0]        fric_r, fric_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        o_speed_r;
  logic [15:0]       o_coast_r, o_est_r;
  logic              o_valid_r, o_rec_r, o_stored_r;
  logic [CNT_W-1:0]  o_cnt_r;
  logic              o_load;

  unit_cmd_t         cmd;
  logic [WIDE_W-1:0] a_o;
  logic [Q_W-1:0]    q_o;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [15:0]       ram_rdata;
  logic [7:0]        rd_s, rd_p;

  logic [31:0]        d1, d2, d3, d4;
  logic [35:0]        lim;
  logic               nf;
  logic [17:0]        w36;
  logic [15:0]        q16;
  logic signed [16:0] qn;
  logic [15:0]        coast_c;
  logic [7:0]         pw_c;
  logic signed [17:0] est_c;

  cpe_unit u_unit (
    .clk (clk),
    .cmd (cmd),
    .a_o (a_o),
    .q_o (q_o)
  );

  cpe_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH)
  ) u_curve (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({speed_r, pw_c}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_s = ram_rdata[15:8];
  assign rd_p = ram_rdata[7:0];

  assign d1  = pt_r[1] - pt_r[0];
  assign d2  = pt_r[2] - pt_r[1];
  assign d3  = pt_r[3] - pt_r[2];
  assign d4  = in_pulse_time_ms - pt_r[3];
  assign lim = 36'(vmin_r) * 36'(d4);
  assign nf  = (d4 != 32'd0) && (36'(wheel_r) >= lim);
  assign w36 = 18'(wheel_r) * 18'd36;

  assign q16 = q_o[16] ? 16'hFFFF : q_o[15:0];
  assign qn  = -$signed({1'b0, q16});

  always_comb begin
    if (neg_r) begin
      coast_c = (q16 > 16'd32768) ? 16'h8000 : qn[15:0];
    end else begin
      coast_c = (q16 > 16'd32767) ? 16'h7FFF : q16;
    end
    if (coast_c[15]) begin
      pw_c = 8'd0;
    end else if (coast_c[15:1] > 15'd255) begin
      pw_c = 8'd255;
    end else begin
      pw_c = coast_c[8:1];
    end
  end

  assign est_c = $signed({8'd0, fric_r}) - 18'($signed(coast_r));

  always_comb begin
    state_nxt  = state_r;
    pt_nxt     = pt_r;
    iv_nxt     = iv_r;
    rec_nxt    = rec_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    t20_nxt    = t20_r;
    t31_nxt    = t31_r;
    t42_nxt    = t42_r;
    diff_nxt   = diff_r;
    neg_nxt    = neg_r;
    speed_nxt  = speed_r;
    num_nxt    = num_r;
    coast_nxt  = coast_r;
    est_nxt    = est_r;
    valid_nxt  = valid_r;
    stored_nxt = stored_r;
    fac_nxt    = fac_r;
    step_nxt   = step_r;
    idx_nxt    = idx_r;
    prev_s_nxt = prev_s_r;
    prev_p_nxt = prev_p_r;
    sb_nxt     = sb_r;
    pb_nxt     = pb_r;
    fric_nxt   = fric_r;
    cmd        = '{op: U_NOP, a_val: '0, b_val: '0, m_val: '0};
    ram_we     = 1'b0;
    ram_raddr  = '0;
    o_load     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          speed_nxt  = '0;
          coast_nxt  = '0;
          est_nxt    = '0;
          valid_nxt  = 1'b0;
          stored_nxt = 1'b0;
          state_nxt  = S_DONE;
          if (in_operation == OP_BUTTON) begin
            rec_nxt = !rec_r;
            if (!rec_r) begin
              cnt_nxt  = '0;
              last_nxt = 8'd255;
            end
          end else begin
            if ((d4 != 32'd0) && !nf) begin
              rec_nxt = 1'b0;
            end
            pt_nxt[0] = pt_r[1];
            pt_nxt[1] = pt_r[2];
            pt_nxt[2] = pt_r[3];
            pt_nxt[3] = in_pulse_time_ms;
            iv_nxt    = {nf, iv_r[3:1]};
            t20_nxt   = {2'b0, d1} + {2'b0, d2};
            t31_nxt   = {2'b0, d2} + {2'b0, d3};
            t42_nxt   = {2'b0, d3} + {2'b0, d4};
            neg_nxt   = d1 > d4;
            diff_nxt  = (d1 > d4) ? (d1 - d4) : (d4 - d1);
            if (nf && iv_r[3] && iv_r[2] && iv_r[1] && (t20_nxt != '0) &&
                (t31_nxt != '0) && (t42_nxt != '0)) begin
              valid_nxt = 1'b1;
              state_nxt = S_SPEED;
            end
          end
        end
      end
      S_SPEED: begin
        cmd.op    = U_LOAD;
        cmd.a_val = WIDE_W'(w36);
        cmd.b_val = WIDE_W'(t31_r) << 8;
        step_nxt  = STEP_W'(8);
        state_nxt = S_SPEED_RUN;
      end
      S_SPEED_RUN: begin
        cmd.op   = U_DIV;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_NUM_LD;
        end
      end
      S_NUM_LD: begin
        speed_nxt = q_o[8] ? 8'd255 : q_o[7:0];
        cmd.op    = U_LOAD;
        cmd.b_val = WIDE_W'(wheel_r);
        cmd.m_val = MUL_W'(wheel_r);
        step_nxt  = STEP_W'(11);
        fac_nxt   = 2'd0;
        state_nxt = S_NUM_RUN;
      end
      S_NUM_RUN: begin
        cmd.op   = U_MUL;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = (fac_r == 2'd3) ? S_DEN_LD : S_NUM_MV;
        end
      end
      S_NUM_MV: begin
        cmd.op  = U_MOVE;
        fac_nxt = fac_r + 1'b1;
        case (fac_r)
          2'd0: begin
            cmd.m_val = MUL_W'(mass_r);
            step_nxt  = STEP_W'(7);
          end
          2'd1: begin
            cmd.m_val = MUL_W'(4000);
            step_nxt  = STEP_W'(11);
          end
          default: begin
            cmd.m_val = MUL_W'(diff_r);
            step_nxt  = STEP_W'(31);
          end
        endcase
        state_nxt = S_NUM_RUN;
      end
      S_DEN_LD: begin
        num_nxt   = a_o[NUM_W-1:0];
        cmd.op    = U_LOAD;
        cmd.b_val = WIDE_W'(t42_r);
        cmd.m_val = t20_r;
        step_nxt  = STEP_W'(33);
        fac_nxt   = 2'd0;
        state_nxt = S_DEN_RUN;
      end
      S_DEN_RUN: begin
        cmd.op   = U_MUL;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = (fac_r == 2'd2) ? S_CDIV_LD : S_DEN_MV;
        end
      end
      S_DEN_MV: begin
        cmd.op    = U_MOVE;
        cmd.m_val = t31_r;
        fac_nxt   = fac_r + 1'b1;
        step_nxt  = STEP_W'(33);
        state_nxt = S_DEN_RUN;
      end
      S_CDIV_LD: begin
        cmd.op    = U_LOAD;
        cmd.a_val = WIDE_W'(num_r);
        cmd.b_val = a_o << 16;
        step_nxt  = STEP_W'(16);
        state_nxt = S_CDIV_RUN;
      end
      S_CDIV_RUN: begin
        cmd.op   = U_DIV;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        coast_nxt = coast_c;
        if (rec_r) begin
          if ((speed_r < last_r) && (cnt_r < CNT_W'(TABLE_DEPTH))) begin
            ram_we     = 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
            last_nxt   = speed_r;
            stored_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SRCH_ST;
        end
      end
      S_SRCH_ST: begin
        ram_raddr = '0;
        idx_nxt   = '0;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if ((idx_r < cnt_r) && (speed_r < rd_s)) begin
          prev_s_nxt = rd_s;
          prev_p_nxt = rd_p;
          idx_nxt    = idx_r + 1'b1;
          ram_raddr  = idx_nxt[IDX_W-1:0];
        end else begin
          if (idx_r < cnt_r) begin
            sb_nxt = rd_s;
            pb_nxt = rd_p;
          end else begin
            sb_nxt = '0;
            pb_nxt = '0;
          end
          state_nxt = S_FRIC;
        end
      end
      S_FRIC: begin
        if ((speed_r == sb_r) || (idx_r == '0) || (prev_s_r <= sb_r)) begin
          fric_nxt  = {1'b0, pb_r, 1'b0};
          state_nxt = S_EST;
        end else begin
          state_nxt = S_INT_LD1;
        end
      end
      S_INT_LD1: begin
        cmd.op    = U_LOAD;
        cmd.b_val = WIDE_W'(prev_p_r);
        cmd.m_val = MUL_W'(speed_r - sb_r);
        step_nxt  = STEP_W'(7);
        state_nxt = S_INT_RUN1;
      end
      S_INT_RUN1: begin
        cmd.op   = U_MUL;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_INT_LD2;
        end
      end
      S_INT_LD2: begin
        cmd.op    = U_LOADB;
        cmd.b_val = WIDE_W'(pb_r);
        cmd.m_val = MUL_W'(prev_s_r - speed_r);
        step_nxt  = STEP_W'(7);
        state_nxt = S_INT_RUN2;
      end
      S_INT_RUN2: begin
        cmd.op   = U_MUL;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_IDIV_LD;
        end
      end
      S_IDIV_LD: begin
        cmd.op    = U_LOAD;
        cmd.a_val = a_o << 1;
        cmd.b_val = WIDE_W'(prev_s_r - sb_r) << 9;
        step_nxt  = STEP_W'(9);
        state_nxt = S_IDIV_RUN;
      end
      S_IDIV_RUN: begin
        cmd.op   = U_DIV;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_IFIN;
        end
      end
      S_IFIN: begin
        fric_nxt  = q_o[9:0];
        state_nxt = S_EST;
      end
      S_EST: begin
        if (est_c > 18'sd32767) begin
          est_nxt = 16'h7FFF;
        end else if (est_c < -18'sd32768) begin
          est_nxt = 16'h8000;
        end else begin
          est_nxt = est_c[15:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          o_load        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wheel_r     <= 12'd2215;
      mass_r      <= 8'd80;
      vmin_r      <= 4'd1;
      pt_r        <= '{default: '0};
      iv_r        <= '0;
      rec_r       <= 1'b0;
      cnt_r       <= '0;
      last_r      <= 8'd255;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pt_r        <= pt_nxt;
      iv_r        <= iv_nxt;
      rec_r       <= rec_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WHEEL: wheel_r <= cfg_data;
          REG_MASS:  mass_r  <= cfg_data[7:0];
          REG_VMIN:  vmin_r  <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    t20_r    <= t20_nxt;
    t31_r    <= t31_nxt;
    t42_r    <= t42_nxt;
    diff_r   <= diff_nxt;
    neg_r    <= neg_nxt;
    speed_r  <= speed_nxt;
    num_r    <= num_nxt;
    coast_r  <= coast_nxt;
    est_r    <= est_nxt;
    valid_r  <= valid_nxt;
    stored_r <= stored_nxt;
    fac_r    <= fac_nxt;
    step_r   <= step_nxt;
    idx_r    <= idx_nxt;
    prev_s_r <= prev_s_nxt;
    prev_p_r <= prev_p_nxt;
    sb_r     <= sb_nxt;
    pb_r     <= pb_nxt;
    fric_r   <= fric_nxt;
    if (o_load) begin
      o_speed_r  <= speed_r;
      o_coast_r  <= coast_r;
      o_est_r    <= est_r;
      o_valid_r  <= valid_r;
      o_rec_r    <= rec_r;
      o_stored_r <= stored_r;
      o_cnt_r    <= cnt_r;
    end
  end

  assign in_ready              = (state_r == S_IDLE);
  assign cfg_ready             = 1'b1;
  assign out_valid             = out_valid_r;
  assign out_speed_code        = o_speed_r;
  assign out_coast_power_w     = o_coast_r;
  assign out_estimated_power_w = o_est_r;
  assign out_window_valid      = o_valid_r;
  assign out_recording         = o_rec_r;
  assign out_point_stored      = o_stored_r;
  assign out_table_entries     = o_cnt_r;

endmodule

### hw/rtl/cpe_checker.sv
// ----------------------------------------------------------------------------
// cpe_checker
// Port-level checks of the coast-down power estimator, bound to the top.
// ----------------------------------------------------------------------------
module cpe_checker import cpe_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         out_speed_code,
  input logic signed [15:0] out_coast_power_w,
  input logic signed [15:0] out_estimated_power_w,
  input logic               out_window_valid,
  input logic               out_recording,
  input logic               out_point_stored,
  input logic [CNT_W-1:0]   out_table_entries
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coast_power_w) &&
    $stable(out_table_entries))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready straight after taking an item");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_valid |-> out_speed_code == 8'd0 &&
    out_coast_power_w == 16'sd0 && out_estimated_power_w == 16'sd0)
    else $error("invalid window with nonzero results");

  a_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_stored |-> out_recording && out_window_valid &&
    out_table_entries != '0)
    else $error("point stored outside record mode");

  a_rec_est: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_recording |-> out_estimated_power_w == 16'sd0)
    else $error("estimate reported while recording");

endmodule

bind coastdown_power_estimator cpe_checker u_cpe_checker (.*);
